// ===== src/ordq_pkg.sv =====
// Shared constants, operation and status codes, and the controller/datapath
// command and status structs of the overwriting ring deque.
// No dependencies.
`default_nettype none

package ordq_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_TOP    = 3'd0;
    localparam logic [2:0] OP_PUSH_BOTTOM = 3'd1;
    localparam logic [2:0] OP_POP_TOP     = 3'd2;
    localparam logic [2:0] OP_POP_BOTTOM  = 3'd3;
    localparam logic [2:0] OP_REMOVE      = 3'd4;
    localparam logic [2:0] OP_READ_RUN    = 3'd5;
    localparam logic [2:0] OP_CLEAR       = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_INIT = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_ZERO_RUN = 2'd3;

    typedef struct packed {
        logic cfg_wr;
        logic exec;
        logic start_loop;
        logic rd_cur;
        logic rd_next;
        logic shift_wr;
        logic shift_done;
        logic read_emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_shift;
        logic need_read;
        logic shift_more;
        logic read_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/overwriting_ring_deque.sv =====
// Overwriting ring deque: a circular double-ended buffer with a capacity
// register. Request channel in_valid/in_stall, result channel
// out_valid/out_stall, capacity write channel cfg_valid/cfg_ready.
// Each request yields one result, or one per entry for a read run; the
// final result of a request has last_of_run set.
// Pushes, pops, clear, error cases and removal of the top or last entry
// need no loop: the result sits in the output register the cycle after
// the request is taken, and such requests can follow every cycle while
// the output is not stalled and no capacity write waits. Remove at an
// inner offset moves each later entry through the memory, a read then a
// write per entry, then posts the result. A read run issues a registered
// memory read and then posts that entry, for each entry returned.
// A capacity write (above DEPTH is taken as DEPTH) empties the buffer;
// cfg_ready is high whenever no loop is running; a waiting write holds requests off.
// Reset clears count, top slot and capacity (not initialized); the entry
// memory is not cleared and needs no clearing pass.
// While out_stall is high with a result in the output register, that result
// is held, in_stall rises and running loops wait before posting the next result.
// Depends on ordq_pkg, ordq_ctrl and ordq_datapath.
`default_nettype none

module overwriting_ring_deque
    import ordq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [31:0] item_value,
    input  wire logic [5:0]  position,
    input  wire logic [6:0]  run_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      read_value,
    output logic             last_of_run,
    output logic [6:0]       entry_count,
    output logic [5:0]       top_position,
    output logic             is_full,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  capacity
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    ordq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ordq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .capacity     (capacity),
        .operation    (operation),
        .item_value   (item_value),
        .position     (position),
        .run_length   (run_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .read_value   (read_value),
        .last_of_run  (last_of_run),
        .entry_count  (entry_count),
        .top_position (top_position),
        .is_full      (is_full)
    );

    // at most one source loads the output register
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec, cmd.shift_done, cmd.read_emit}))
        else $error("several result sources in one cycle");

    // a request that needs no loop posts its result the next cycle
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !cfg_valid && !sts.need_shift && !sts.need_read)
        |=> out_valid)
        else $error("single-cycle request gave no result");

    // a shift write always follows the read of the entry it moves
    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> $past(cmd.rd_next))
        else $error("shift write without preceding read");

    // the reported count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= 7'(DEPTH)))
        else $error("entry count above depth");

endmodule

`default_nettype wire

// ===== src/ordq_ctrl.sv =====
// Sequencer of the overwriting ring deque: accepts requests, runs the
// remove-shift and read-run loops. Depends on ordq_pkg.
`default_nettype none

module ordq_ctrl
    import ordq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SH_READ  = 6'b000010,
        S_SH_WRITE = 6'b000100,
        S_SH_DONE  = 6'b001000,
        S_RD_ISSUE = 6'b010000,
        S_RD_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign cfg_ready = (state_reg == S_IDLE);
    // hold requests off while a capacity write is waiting
    assign in_stall  = !((state_reg == S_IDLE) && sts.out_free && !cfg_valid);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_wr = 1'b1;
                end
                else if (accept)
                begin
                    if (sts.need_shift)
                    begin
                        cmd.start_loop = 1'b1;
                        state_next     = S_SH_READ;
                    end
                    else if (sts.need_read)
                    begin
                        cmd.start_loop = 1'b1;
                        state_next     = S_RD_ISSUE;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_SH_READ:
            begin
                cmd.rd_next = 1'b1;
                state_next  = S_SH_WRITE;
            end
            S_SH_WRITE:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = sts.shift_more ? S_SH_READ : S_SH_DONE;
            end
            S_SH_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.shift_done = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.read_emit = 1'b1;
                    state_next    = sts.read_last ? S_IDLE : S_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ordq_datapath.sv =====
// Datapath of the overwriting ring deque: entry memory, top/count/capacity
// registers, loop index and the output register. Depends on ordq_pkg.
`default_nettype none

module ordq_datapath
    import ordq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctl_cmd_t    cmd,
    output dp_sts_t          sts,
    input  wire logic [6:0]  capacity,
    input  wire logic [2:0]  operation,
    input  wire logic [31:0] item_value,
    input  wire logic [5:0]  position,
    input  wire logic [6:0]  run_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      read_value,
    output logic             last_of_run,
    output logic [6:0]       entry_count,
    output logic [5:0]       top_position,
    output logic             is_full
);

    logic [DATA_WIDTH-1:0] store_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [ADDR_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg;
    logic [31:0]       value_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] otop_reg;
    logic              full_reg;

    // physical slot of a logical offset from the top
    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] top,
        input logic [CNT_W-1:0]  off,
        input logic [CNT_W-1:0]  cap
    );
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(top) + (CNT_W + 1)'(off);
        if (cap != '0 && s >= (CNT_W + 1)'(cap))
        begin
            s = s - (CNT_W + 1)'(cap);
        end
        if (s >= (CNT_W + 1)'(DEPTH))
        begin
            s = '0;
        end
        return ADDR_W'(s);
    endfunction

    logic              cap_zero;
    logic [6:0]        pos_w;
    logic [6:0]        held_w;
    logic              pos_in_range;
    logic [CNT_W-1:0]  pos_c;
    logic [CNT_W:0]    top_sum;
    logic [ADDR_W-1:0] top_inc;
    logic [ADDR_W-1:0] top_dec;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W-1:0]  run_n;

    assign cap_zero     = (cap_reg == '0);
    assign pos_w        = 7'(position);
    assign held_w       = 7'(held_reg);
    assign pos_in_range = pos_w < held_w;
    assign pos_c        = CNT_W'(position);
    assign top_sum      = (CNT_W + 1)'(top_reg) + (CNT_W + 1)'(1);
    assign top_inc      = (top_sum >= (CNT_W + 1)'(cap_reg)) ? '0 : ADDR_W'(top_sum);
    assign top_dec      = (top_reg == '0) ? ADDR_W'(cap_reg - CNT_W'(1))
                                          : top_reg - ADDR_W'(1);
    assign avail        = held_reg - pos_c;
    assign run_n        = (run_length < 7'(avail)) ? CNT_W'(run_length) : avail;

    always_comb
    begin
        sts.need_shift = !cap_zero && (operation == OP_REMOVE) && pos_in_range
                         && (position != '0) && ((8'(pos_w) + 8'd1) < 8'(held_w));
        sts.need_read  = !cap_zero && (operation == OP_READ_RUN) && pos_in_range
                         && (run_length != '0);
        sts.shift_more = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(held_reg);
        sts.read_last  = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(end_reg);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // operations that need no loop
    logic [ADDR_W-1:0] ex_top;
    logic [CNT_W-1:0]  ex_held;
    logic              ex_we;
    logic [ADDR_W-1:0] ex_waddr;
    logic [1:0]        ex_status;

    always_comb
    begin
        ex_top    = top_reg;
        ex_held   = held_reg;
        ex_we     = 1'b0;
        ex_waddr  = top_reg;
        ex_status = ST_OK;
        if (cap_zero)
        begin
            ex_status = ST_NOT_INIT;
        end
        else
        begin
            unique case (operation)
                OP_PUSH_TOP:
                begin
                    ex_top   = top_dec;
                    ex_held  = (held_reg < cap_reg) ? held_reg + CNT_W'(1) : held_reg;
                    ex_we    = 1'b1;
                    ex_waddr = top_dec;
                end
                OP_PUSH_BOTTOM:
                begin
                    if (held_reg < cap_reg)
                    begin
                        ex_held = held_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ex_top = top_inc;
                    end
                    ex_we    = 1'b1;
                    ex_waddr = slot_of(ex_top, ex_held - CNT_W'(1), cap_reg);
                end
                OP_POP_TOP:
                begin
                    if (held_reg != '0)
                    begin
                        ex_top  = top_inc;
                        ex_held = held_reg - CNT_W'(1);
                    end
                end
                OP_POP_BOTTOM:
                begin
                    if (held_reg != '0)
                    begin
                        ex_held = held_reg - CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    // only the top or the last entry, or an out-of-range position, gets here: no shift needed
                    if (pos_in_range)
                    begin
                        if (position == '0)
                        begin
                            ex_top = top_inc;
                        end
                        ex_held = held_reg - CNT_W'(1);
                    end
                end
                OP_READ_RUN:
                begin
                    ex_status = pos_in_range ? ST_ZERO_RUN : ST_RANGE;
                end
                OP_CLEAR:
                begin
                    ex_top  = '0;
                    ex_held = '0;
                end
                default:
                begin
                    ex_status = ST_OK;
                end
            endcase
        end
    end

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  load;
    logic [1:0]            res_status;
    logic [31:0]           res_value;
    logic                  res_last;
    logic [CNT_W-1:0]      res_count;
    logic [ADDR_W-1:0]     res_top;

    assign mem_re    = cmd.rd_cur || cmd.rd_next;
    assign mem_raddr = cmd.rd_next ? slot_of(top_reg, idx_reg + CNT_W'(1), cap_reg)
                                   : slot_of(top_reg, idx_reg, cap_reg);

    always_comb
    begin
        top_next   = top_reg;
        held_next  = held_reg;
        cap_next   = cap_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        mem_we     = 1'b0;
        mem_waddr  = ex_waddr;
        mem_wdata  = DATA_WIDTH'(item_value);
        load       = 1'b0;
        res_status = ST_OK;
        res_value  = '0;
        res_last   = 1'b1;
        res_count  = held_reg;
        res_top    = top_reg;
        if (cmd.cfg_wr)
        begin
            cap_next  = (capacity > 7'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity);
            top_next  = '0;
            held_next = '0;
        end
        if (cmd.exec)
        begin
            top_next   = ex_top;
            held_next  = ex_held;
            mem_we     = ex_we;
            load       = 1'b1;
            res_status = ex_status;
            res_count  = ex_held;
            res_top    = ex_top;
        end
        if (cmd.start_loop)
        begin
            idx_next = pos_c;
            end_next = pos_c + run_n;
        end
        if (cmd.shift_wr)
        begin
            // close the gap: entry at idx+1 moves down to idx
            mem_we    = 1'b1;
            mem_waddr = slot_of(top_reg, idx_reg, cap_reg);
            mem_wdata = rd_data_reg;
            idx_next  = idx_reg + CNT_W'(1);
        end
        if (cmd.shift_done)
        begin
            held_next = held_reg - CNT_W'(1);
            load      = 1'b1;
            res_count = held_reg - CNT_W'(1);
        end
        if (cmd.read_emit)
        begin
            load      = 1'b1;
            res_value = 32'(rd_data_reg);
            res_last  = sts.read_last;
            idx_next  = idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            held_reg      <= '0;
            cap_reg       <= '0;
            idx_reg       <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            held_reg      <= held_next;
            cap_reg       <= cap_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= res_status;
            value_reg  <= res_value;
            last_reg   <= res_last;
            count_reg  <= res_count;
            otop_reg   <= res_top;
            full_reg   <= (cap_next == '0) || (res_count >= cap_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_reg[mem_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign read_value   = value_reg;
    assign last_of_run  = last_reg;
    assign entry_count  = 7'(count_reg);
    assign top_position = 6'(otop_reg);
    assign is_full      = full_reg;

endmodule

`default_nettype wire
